>>> rtl/core/gouraud_span_interpolator_core_defines.svh
// Assertion macros used by the span interpolator controller.
// No dependencies; expects clk and rst in the including scope.
`ifndef GOURAUD_SPAN_INTERPOLATOR_CORE_DEFINES_SVH
`define GOURAUD_SPAN_INTERPOLATOR_CORE_DEFINES_SVH

// antecedent holds -> consequent holds in the same cycle
`define GSI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// antecedent holds -> consequent holds in the next cycle
`define GSI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/gsi_pkg.sv
// Shared types and constants for the Gouraud span interpolator.
// No dependencies.
package gsi_pkg;

  localparam int MAX_SPAN_DEF = 64;
  localparam int X_W    = 12;
  localparam int C_W    = 24;
  localparam int DIV_DW = 40;   // |delta| << 16, or colour << 16
  localparam int STEP_W = 41;
  localparam int PROD_W = 55;
  localparam int ACC_W  = 56;

  localparam logic [2:0] CFG_MODE  = 3'd0;
  localparam logic [2:0] CFG_RED   = 3'd1;
  localparam logic [2:0] CFG_GREEN = 3'd2;
  localparam logic [2:0] CFG_BLUE  = 3'd3;
  localparam logic [2:0] CFG_ALPHA = 3'd4;

  localparam logic [1:0] MODE_LINEAR   = 2'd0;
  localparam logic [1:0] MODE_ENDPOINT = 2'd1;
  localparam logic [1:0] MODE_PERSP    = 2'd2;
  localparam logic [1:0] MODE_RESERVED = 2'd3;  // treated as linear

  localparam logic [1:0] SEL_ESTART = 2'd0;
  localparam logic [1:0] SEL_EEND   = 2'd1;
  localparam logic [1:0] SEL_GRAD   = 2'd2;

  localparam logic [4:0]  RED_RST   = 5'd16;
  localparam logic [4:0]  GREEN_RST = 5'd8;
  localparam logic [4:0]  BLUE_RST  = 5'd0;
  localparam logic [31:0] ALPHA_RST = 32'hFF00_0000;

  typedef struct packed {
    logic [X_W-1:0] seg_start_x;
    logic [X_W-1:0] seg_end_x;
    logic [X_W-1:0] first_x;
    logic [X_W-1:0] last_x;
    logic [C_W-1:0] start_red;
    logic [C_W-1:0] start_green;
    logic [C_W-1:0] start_blue;
    logic [C_W-1:0] start_weight;
    logic [C_W-1:0] end_red;
    logic [C_W-1:0] end_green;
    logic [C_W-1:0] end_blue;
    logic [C_W-1:0] end_weight;
  } span_t;

  typedef struct packed {
    logic [31:0]    pixel_color;
    logic [X_W-1:0] pixel_x;
    logic           last_pixel;
    logic           span_truncated;
  } pixel_t;

  typedef struct packed {
    logic       load;
    logic       div_go;
    logic       div_take;
    logic [1:0] div_sel;
    logic       mul;
    logic       add;
    logic       pdiv_init;
    logic       pdiv_step;
    logic       emit;
    logic       advance;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic empty;
    logic mode_div;
    logic persp;
    logic last;
  } sts_t;

endpackage

>>> rtl/core/gsi_ifs.sv
// Handshake channels of the span interpolator: span items in, pixel items out.
// Depends on gsi_pkg for field widths.
interface gsi_span_if;
  logic                    valid;
  logic                    ready;
  logic [gsi_pkg::X_W-1:0] seg_start_x;
  logic [gsi_pkg::X_W-1:0] seg_end_x;
  logic [gsi_pkg::X_W-1:0] first_x;
  logic [gsi_pkg::X_W-1:0] last_x;
  logic [gsi_pkg::C_W-1:0] start_red;
  logic [gsi_pkg::C_W-1:0] start_green;
  logic [gsi_pkg::C_W-1:0] start_blue;
  logic [gsi_pkg::C_W-1:0] start_weight;
  logic [gsi_pkg::C_W-1:0] end_red;
  logic [gsi_pkg::C_W-1:0] end_green;
  logic [gsi_pkg::C_W-1:0] end_blue;
  logic [gsi_pkg::C_W-1:0] end_weight;

  modport source(output valid, seg_start_x, seg_end_x, first_x, last_x, start_red,
                 start_green, start_blue, start_weight, end_red, end_green, end_blue,
                 end_weight, input ready);
  modport sink(input valid, seg_start_x, seg_end_x, first_x, last_x, start_red,
               start_green, start_blue, start_weight, end_red, end_green, end_blue,
               end_weight, output ready);
endinterface

interface gsi_pixel_if;
  logic                    valid;
  logic                    ready;
  logic [31:0]             pixel_color;
  logic [gsi_pkg::X_W-1:0] pixel_x;
  logic                    last_pixel;
  logic                    span_truncated;

  modport source(output valid, pixel_color, pixel_x, last_pixel, span_truncated,
                 input ready);
  modport sink(input valid, pixel_color, pixel_x, last_pixel, span_truncated,
               output ready);
endinterface

>>> rtl/core/gsi_div.sv
// Serial restoring unsigned divider, one quotient bit per cycle.
// No package dependencies.
module gsi_div #(
  parameter int DW = 40,
  parameter int VW = 24
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic [DW-1:0] quotient,
  output logic          done
);
  localparam int CW = $clog2(DW);

  logic [VW-1:0] rem;
  logic [DW-1:0] dvd;
  logic [VW-1:0] dvs;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [VW:0]   trial;
  logic [VW:0]   diff;
  logic          ge;

  assign trial    = {rem, dvd[DW-1]};
  assign diff     = trial - {1'b0, dvs};
  assign ge       = trial >= {1'b0, dvs};
  assign quotient = dvd;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(DW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvd <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      rem <= ge ? diff[VW-1:0] : trial[VW-1:0];
      dvd <= {dvd[DW-2:0], ge};
    end
  end
endmodule

>>> rtl/core/gsi_dp.sv
// Datapath: config registers, setup dividers, accumulators, per-pixel divide, packing.
// Depends on gsi_pkg and gsi_div.
module gsi_dp #(
  parameter int MAX_SPAN = gsi_pkg::MAX_SPAN_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_write,
  input  logic [2:0]     cfg_index,
  input  logic [31:0]    cfg_data,
  input  gsi_pkg::span_t span,
  input  gsi_pkg::cmd_t  cmd,
  output gsi_pkg::sts_t  sts,
  output gsi_pkg::pixel_t pix
);
  localparam int CNT_W = $clog2(MAX_SPAN + 1);
  localparam int XW    = gsi_pkg::X_W;
  localparam int CW    = gsi_pkg::C_W;
  localparam int DW    = gsi_pkg::DIV_DW;
  localparam int SW    = gsi_pkg::STEP_W;
  localparam int PW    = gsi_pkg::PROD_W;
  localparam int AW    = gsi_pkg::ACC_W;

  logic [1:0]  mode;
  logic [4:0]  red_shift, green_shift, blue_shift;
  logic [31:0] alpha_fill;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= gsi_pkg::MODE_LINEAR;
      red_shift   <= gsi_pkg::RED_RST;
      green_shift <= gsi_pkg::GREEN_RST;
      blue_shift  <= gsi_pkg::BLUE_RST;
      alpha_fill  <= gsi_pkg::ALPHA_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        gsi_pkg::CFG_MODE:  mode        <= cfg_data[1:0];
        gsi_pkg::CFG_RED:   red_shift   <= cfg_data[4:0];
        gsi_pkg::CFG_GREEN: green_shift <= cfg_data[4:0];
        gsi_pkg::CFG_BLUE:  blue_shift  <= cfg_data[4:0];
        gsi_pkg::CFG_ALPHA: alpha_fill  <= cfg_data;
        default: ;
      endcase
    end
  end

  // lanes 0..2 are R, G, B; lane 3 is w
  logic [CW-1:0]        s_v [4];
  logic [CW-1:0]        e_v [4];
  logic [12:0]          len;
  logic signed [13:0]   dx;
  logic [XW-1:0]        x;
  logic [CNT_W-1:0]     cnt;
  logic                 cut;
  logic                 empty;
  logic [12:0]          count;

  logic                 neg [4];
  logic [CW-1:0]        mag [4];
  logic [DW-1:0]        dvd_in [4];
  logic [CW-1:0]        dvs_in [4];
  logic [DW-1:0]        quo [4];
  logic                 done [4];

  logic signed [SW-1:0] step [4];
  logic signed [PW-1:0] prod [4];
  logic signed [AW-1:0] acc [4];

  assign count = {1'b0, span.last_x} - {1'b0, span.first_x} + 13'd1;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      neg[k] = e_v[k] < s_v[k];
      mag[k] = neg[k] ? s_v[k] - e_v[k] : e_v[k] - s_v[k];
      unique case (cmd.div_sel)
        gsi_pkg::SEL_ESTART: begin
          dvd_in[k] = {s_v[k], 16'b0};
          dvs_in[k] = s_v[3];
        end
        gsi_pkg::SEL_EEND: begin
          dvd_in[k] = {e_v[k], 16'b0};
          dvs_in[k] = e_v[3];
        end
        default: begin
          dvd_in[k] = {mag[k], 16'b0};
          dvs_in[k] = {11'b0, len};
        end
      endcase
    end
  end

  for (genvar g = 0; g < 4; g++) begin : g_lane
    gsi_div #(.DW(DW), .VW(CW)) u_div (
      .clk      (clk),
      .rst      (rst),
      .start    (cmd.div_go),
      .dividend (dvd_in[g]),
      .divisor  (dvs_in[g]),
      .quotient (quo[g]),
      .done     (done[g])
    );
  end

  function automatic logic [CW-1:0] ep_sat(logic [DW-1:0] q, logic [CW-1:0] w);
    logic [CW-1:0] r;
    if (w == '0) r = 24'h00FF00;
    else if (q[DW-1:CW] != '0) r = '1;
    else r = q[CW-1:0];
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      s_v[0] <= span.start_red;
      s_v[1] <= span.start_green;
      s_v[2] <= span.start_blue;
      s_v[3] <= span.start_weight;
      e_v[0] <= span.end_red;
      e_v[1] <= span.end_green;
      e_v[2] <= span.end_blue;
      e_v[3] <= span.end_weight;
      len    <= (span.seg_end_x >= span.seg_start_x) ?
                {1'b0, span.seg_end_x} - {1'b0, span.seg_start_x} + 13'd1 : 13'd1;
      dx     <= $signed({2'b0, span.first_x}) - $signed({2'b0, span.seg_start_x});
      empty  <= span.last_x < span.first_x;
      cut    <= count > 13'(MAX_SPAN);
      cnt    <= (count > 13'(MAX_SPAN)) ? CNT_W'(MAX_SPAN) : count[CNT_W-1:0];
      x      <= span.first_x;
    end else if (cmd.div_take) begin
      for (int k = 0; k < 3; k++) begin
        if (cmd.div_sel == gsi_pkg::SEL_ESTART) s_v[k] <= ep_sat(quo[k], s_v[3]);
        else if (cmd.div_sel == gsi_pkg::SEL_EEND) e_v[k] <= ep_sat(quo[k], e_v[3]);
      end
      if (cmd.div_sel == gsi_pkg::SEL_GRAD) begin
        for (int k = 0; k < 4; k++)
          step[k] <= neg[k] ? -$signed({1'b0, quo[k]}) : $signed({1'b0, quo[k]});
      end
    end else if (cmd.mul) begin
      for (int k = 0; k < 4; k++) prod[k] <= PW'(step[k]) * PW'(dx);
    end else if (cmd.add) begin
      for (int k = 0; k < 4; k++)
        acc[k] <= AW'($signed({1'b0, s_v[k], 16'b0})) + AW'(prod[k]);
    end else if (cmd.advance) begin
      for (int k = 0; k < 4; k++) acc[k] <= acc[k] + AW'(step[k]);
      x   <= x + 1'b1;
      cnt <= cnt - 1'b1;
    end
  end

  // per-pixel divide: acc / wacc, 8 fractional quotient bits
  logic [AW:0]  prem [3];
  logic [7:0]   pq [3];
  logic         pfix [3];
  logic [7:0]   pfv [3];
  logic [AW:0]  ptrial [3];
  logic         pge [3];
  logic [AW:0]  wide_w;

  assign wide_w = {1'b0, acc[3]};

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ptrial[k] = {prem[k][AW-1:0], 1'b0};
      pge[k]    = ptrial[k] >= wide_w;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      if (cmd.pdiv_init) begin
        prem[k] <= {1'b0, acc[k]};
        pq[k]   <= '0;
        if (acc[3] <= 0) begin
          pfix[k] <= 1'b1;
          pfv[k]  <= 8'hFF;
        end else if (acc[k] <= 0) begin
          pfix[k] <= 1'b1;
          pfv[k]  <= 8'h00;
        end else if (acc[k] >= acc[3]) begin
          pfix[k] <= 1'b1;
          pfv[k]  <= 8'hFF;
        end else begin
          pfix[k] <= 1'b0;
          pfv[k]  <= 8'h00;
        end
      end else if (cmd.pdiv_step) begin
        prem[k] <= pge[k] ? ptrial[k] - wide_w : ptrial[k];
        pq[k]   <= {pq[k][6:0], pge[k]};
      end
    end
  end

  logic [7:0] ch [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (mode == gsi_pkg::MODE_PERSP) ch[k] = pfix[k] ? pfv[k] : pq[k];
      else if (acc[k][AW-1]) ch[k] = 8'h00;
      else if (acc[k][AW-2:32] != '0) ch[k] = 8'hFF;
      else ch[k] = acc[k][31:24];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      pix.pixel_color    <= alpha_fill | (32'(ch[0]) << red_shift)
                          | (32'(ch[1]) << green_shift) | (32'(ch[2]) << blue_shift);
      pix.pixel_x        <= x;
      pix.last_pixel     <= cnt == CNT_W'(1);
      pix.span_truncated <= cut;
    end
  end

  // all four lanes start together and finish together
  assign sts.div_done = done[0] & done[1] & done[2] & done[3];
  assign sts.empty    = empty;
  assign sts.mode_div = mode == gsi_pkg::MODE_ENDPOINT;
  assign sts.persp    = mode == gsi_pkg::MODE_PERSP;
  assign sts.last     = cnt == CNT_W'(1);
endmodule

>>> rtl/core/gsi_ctrl.sv
// Controller: sequences setup divisions, accumulator set-up and pixel emission.
// Depends on gsi_pkg and the assertion macro header.
`include "gouraud_span_interpolator_core_defines.svh"
module gsi_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  gsi_pkg::sts_t sts,
  output gsi_pkg::cmd_t cmd
);
  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_SETUP = 4'd1;
  localparam logic [3:0] ST_EDS   = 4'd2;
  localparam logic [3:0] ST_EGO   = 4'd3;
  localparam logic [3:0] ST_EDE   = 4'd4;
  localparam logic [3:0] ST_GGO   = 4'd5;
  localparam logic [3:0] ST_GRD   = 4'd6;
  localparam logic [3:0] ST_MUL   = 4'd7;
  localparam logic [3:0] ST_ADD   = 4'd8;
  localparam logic [3:0] ST_PIX   = 4'd9;
  localparam logic [3:0] ST_PDV   = 4'd10;
  localparam logic [3:0] ST_PEM   = 4'd11;
  localparam logic [3:0] ST_OUT   = 4'd12;

  logic [3:0] state, state_next;
  logic [2:0] pcnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      pcnt  <= '0;
    end else begin
      state <= state_next;
      if (state == ST_PDV) pcnt <= pcnt + 1'b1;
      else pcnt <= '0;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.div_sel = gsi_pkg::SEL_GRAD;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_SETUP;
        end
      end
      ST_SETUP: begin
        if (sts.empty) state_next = ST_IDLE;
        else if (sts.mode_div) begin
          cmd.div_go  = 1'b1;
          cmd.div_sel = gsi_pkg::SEL_ESTART;
          state_next  = ST_EDS;
        end else state_next = ST_GGO;
      end
      ST_EDS: begin
        cmd.div_sel = gsi_pkg::SEL_ESTART;
        if (sts.div_done) begin
          cmd.div_take = 1'b1;
          state_next   = ST_EGO;
        end
      end
      ST_EGO: begin
        cmd.div_sel = gsi_pkg::SEL_EEND;
        cmd.div_go  = 1'b1;
        state_next  = ST_EDE;
      end
      ST_EDE: begin
        cmd.div_sel = gsi_pkg::SEL_EEND;
        if (sts.div_done) begin
          cmd.div_take = 1'b1;
          state_next   = ST_GGO;
        end
      end
      ST_GGO: begin
        cmd.div_go = 1'b1;
        state_next = ST_GRD;
      end
      ST_GRD: begin
        if (sts.div_done) begin
          cmd.div_take = 1'b1;
          state_next   = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_ADD;
      end
      ST_ADD: begin
        cmd.add    = 1'b1;
        state_next = ST_PIX;
      end
      ST_PIX: begin
        if (sts.persp) begin
          cmd.pdiv_init = 1'b1;
          state_next    = ST_PDV;
        end else begin
          cmd.emit   = 1'b1;
          state_next = ST_OUT;
        end
      end
      ST_PDV: begin
        cmd.pdiv_step = 1'b1;
        if (pcnt == 3'd7) state_next = ST_PEM;
      end
      ST_PEM: begin
        cmd.emit   = 1'b1;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          cmd.advance = 1'b1;
          state_next  = sts.last ? ST_IDLE : ST_PIX;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  `GSI_ASSERT_NEXT(a_accept_setup, in_valid && in_ready, state == ST_SETUP, "item not set up")
  `GSI_ASSERT_NOW(a_done_waiting, sts.div_done, state == ST_EDS || state == ST_EDE || state == ST_GRD, "stray divider done")
  `GSI_ASSERT_NEXT(a_last_idle, out_valid && out_ready && sts.last, state == ST_IDLE, "span did not end")
  `GSI_ASSERT_NEXT(a_pdiv_len, state == ST_PDV && pcnt == 3'd7, state == ST_PEM, "pixel divide overran")
endmodule

>>> rtl/core/gouraud_span_interpolator_core.sv
// Top level of the Gouraud span interpolator: controller plus datapath.
// Depends on gsi_pkg, gsi_ifs, gsi_ctrl and gsi_dp.
//
//   port       dir  payload
//   span_in    in   segment x range, drawn range, endpoint RGB and w
//   pixel_out  out  packed colour, x, last flag, truncation flag
//   cfg_*      in   register writes, no read-back
//
// Set-up of each span runs the 40-step serial dividers: in mode 1 the endpoint
// divides run first, then the gradients; the other modes run the gradients only.
// Each pixel is then emitted; in mode 2 an 8-step divide runs before each one.
// Reset (rst, synchronous) restores register defaults and idles the controller.
// A stalled pixel holds in the output register until taken.
module gouraud_span_interpolator_core #(
  parameter int MAX_SPAN = gsi_pkg::MAX_SPAN_DEF
) (
  input  logic        clk,
  input  logic        rst,
  gsi_span_if.sink    span_in,
  gsi_pixel_if.source pixel_out,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  gsi_pkg::span_t  span;
  gsi_pkg::pixel_t pix;
  gsi_pkg::cmd_t   cmd;
  gsi_pkg::sts_t   sts;

  assign span.seg_start_x  = span_in.seg_start_x;
  assign span.seg_end_x    = span_in.seg_end_x;
  assign span.first_x      = span_in.first_x;
  assign span.last_x       = span_in.last_x;
  assign span.start_red    = span_in.start_red;
  assign span.start_green  = span_in.start_green;
  assign span.start_blue   = span_in.start_blue;
  assign span.start_weight = span_in.start_weight;
  assign span.end_red      = span_in.end_red;
  assign span.end_green    = span_in.end_green;
  assign span.end_blue     = span_in.end_blue;
  assign span.end_weight   = span_in.end_weight;

  assign pixel_out.pixel_color    = pix.pixel_color;
  assign pixel_out.pixel_x        = pix.pixel_x;
  assign pixel_out.last_pixel     = pix.last_pixel;
  assign pixel_out.span_truncated = pix.span_truncated;

  gsi_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (span_in.valid),
    .in_ready  (span_in.ready),
    .out_valid (pixel_out.valid),
    .out_ready (pixel_out.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  gsi_dp #(.MAX_SPAN(MAX_SPAN)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .span      (span),
    .cmd       (cmd),
    .sts       (sts),
    .pix       (pix)
  );
endmodule
